/* src/ced_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny edge stream package
// Shared constants, types and helper functions of the edge detector.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4095;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LOW    = 2'd2,
    CFG_HIGH   = 2'd3
  } cfg_idx_e;

  // Gradient direction sectors.
  localparam logic [1:0] SEC_HORZ    = 2'd0;
  localparam logic [1:0] SEC_DIAG_UP = 2'd1;
  localparam logic [1:0] SEC_VERT    = 2'd2;
  localparam logic [1:0] SEC_DIAG_DN = 2'd3;

  // Per-item sequencer of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_MID,
    ST_GRAY,
    ST_GRAD,
    ST_MAG,
    ST_SUPP,
    ST_OUT
  } ctl_state_e;

  // Gradient unit sequencer.
  typedef enum logic [2:0] {
    GR_IDLE,
    GR_LOAD,
    GR_PROD,
    GR_ROOT,
    GR_DONE
  } grad_state_e;

  typedef logic [7:0] pix_t;
  typedef logic [2:0][2:0][7:0] gwin_t;

  // Luma with fixed-point weights 0.3, 0.59 and 0.11 scaled by 2^16.
  function automatic pix_t gray_of(input pix_t r, input pix_t g, input pix_t b);
    logic [23:0] s;
    s = 16'd19661 * r + 16'd38666 * g + 16'd7209 * b;
    return s[23:16];
  endfunction

endpackage

/* src/ced_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ced_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/ced_grad.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny gradient unit
// Sobel gradient of a 3x3 gray window: magnitude by a bitwise square root
// and direction sector, sharing one squaring multiplier over the steps.
// ----------------------------------------------------------------------------
module ced_grad import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  gwin_t      win_i,
  output logic       done_o,
  output logic [7:0] mag_o,
  output logic [1:0] sector_o
);

  grad_state_e state_q, state_d;
  logic [2:0]  step_q;
  logic [9:0]  a_q, b_q;
  logic        gxpos_q;
  logic [19:0] a2_q, bma2_q;
  logic [20:0] s_q;
  logic [21:0] apb2_q;
  logic [7:0]  root_q;
  logic [7:0]  trial;
  logic [10:0] op;
  logic [21:0] prod;

  logic signed [11:0] gx, gy, gxn, gyn;

  // Gradient of the window, folded into the upper half plane.
  always_comb begin
    gx = ($signed({4'b0, win_i[0][2]}) + ($signed({4'b0, win_i[1][2]}) <<< 1)
          + $signed({4'b0, win_i[2][2]}))
       - ($signed({4'b0, win_i[0][0]}) + ($signed({4'b0, win_i[1][0]}) <<< 1)
          + $signed({4'b0, win_i[2][0]}));
    gy = ($signed({4'b0, win_i[2][0]}) + ($signed({4'b0, win_i[2][1]}) <<< 1)
          + $signed({4'b0, win_i[2][2]}))
       - ($signed({4'b0, win_i[0][0]}) + ($signed({4'b0, win_i[0][1]}) <<< 1)
          + $signed({4'b0, win_i[0][2]}));
    if (gy[11]) begin
      gxn = -gx;
      gyn = -gy;
    end else begin
      gxn = gx;
      gyn = gy;
    end
  end

  assign trial = root_q | (8'h80 >> step_q);

  always_comb begin
    op = '0;
    case (state_q)
      GR_PROD: begin
        case (step_q)
          3'd0:    op = {1'b0, a_q};
          3'd1:    op = {1'b0, b_q};
          3'd2:    op = {1'b0, a_q} + {1'b0, b_q};
          default: op = (b_q > a_q) ? {1'b0, b_q - a_q} : '0;
        endcase
      end
      GR_ROOT: op = {3'b0, trial};
      default: op = '0;
    endcase
  end

  assign prod = 22'(op) * 22'(op);

  always_comb begin
    state_d = state_q;
    case (state_q)
      GR_IDLE: if (start_i) state_d = GR_LOAD;
      GR_LOAD: state_d = GR_PROD;
      GR_PROD: if (step_q == 3'd3) state_d = GR_ROOT;
      GR_ROOT: if (step_q == 3'd7) state_d = GR_DONE;
      GR_DONE: state_d = GR_IDLE;
      default: state_d = GR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == GR_LOAD || (state_q == GR_PROD && step_q == 3'd3)) begin
        step_q <= '0;
      end else if (state_q == GR_PROD || state_q == GR_ROOT) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      GR_LOAD: begin
        a_q     <= gxn[11] ? 10'(-gxn) : 10'(gxn);
        b_q     <= 10'(gyn);
        gxpos_q <= !gxn[11];
        root_q  <= '0;
      end
      GR_PROD: begin
        case (step_q)
          3'd0:    a2_q   <= prod[19:0];
          3'd1:    s_q    <= {1'b0, a2_q} + prod[20:0];
          3'd2:    apb2_q <= prod;
          default: bma2_q <= prod[19:0];
        endcase
      end
      GR_ROOT: begin
        if (prod <= {1'b0, s_q}) root_q <= trial;
      end
      default: ;
    endcase
  end

  always_comb begin
    done_o   = (state_q == GR_DONE);
    mag_o    = (s_q[20:16] != '0) ? 8'd255 : root_q;
    if (a_q == '0 && b_q == '0) begin
      sector_o = SEC_HORZ;
    end else if (apb2_q < {1'b0, a2_q, 1'b0}) begin
      sector_o = SEC_HORZ;
    end else if (b_q > a_q && {1'b0, bma2_q} > {a2_q, 1'b0}) begin
      sector_o = SEC_VERT;
    end else begin
      sector_o = gxpos_q ? SEC_DIAG_UP : SEC_DIAG_DN;
    end
  end

endmodule

/* src/canny_edge_stream_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny edge stream core
// RGB to gray, Sobel gradient, non-maximum suppression and hysteresis on
// three 3x3 windows, each fed by a two-row line store held in RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  -----------------------------
//  in       sink       in_valid_i / in_stall_o red_i, green_i, blue_i
//  out      source     out_valid_o/out_stall_i edge_res_o, last_in_frame_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each request runs from its accept through two line store reads, the gray
// window update, the gradient unit (load, a four-step squaring pass on one
// shared multiplier, an eight-step square root, done), the magnitude and
// suppression window updates, and the output state; no new request is
// taken before it is done.
// Reset clears the windows, the frame counters and the output valid flag; the
// line stores are not cleared, since unwritten entries only feed border
// pixels, which are forced to zero. A finished result waits in the output
// register while the next request is taken; the sequencer stalls only when
// it must hand over a new result and the previous one is still held.
// A request leaves a result 3*width+3 requests after it enters.
module canny_edge_stream_core import ced_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        edge_res_o,
  output logic        last_in_frame_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT + 5);
  localparam int WEffW = $clog2(MAX_WIDTH + 1);
  localparam int HEffW = $clog2(MAX_HEIGHT + 1);
  localparam int AddrW = ColW + 1;
  localparam int Depth = 2 ** AddrW;
  localparam int WRst  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int HRst  = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  ctl_state_e state_q, state_d;

  // Configuration, sizes kept already clamped.
  logic [WEffW-1:0] w_q;
  logic [HEffW-1:0] h_q;
  logic [7:0]       low_q, high_q;
  logic             cfg_we, size_we;

  // Accepted pixel.
  logic [7:0] red_q, green_q, blue_q;

  // Stream positions: stage 0 gray, 1 magnitude, 2 suppression, 3 output.
  logic [ColW-1:0] col_q [4];
  logic [RowW-1:0] row_q [4];
  logic [3:0]      en, inner, last_col;

  // Windows.
  gwin_t                 gwin_q;
  logic [2:0][2:0][9:0]  mwin_q;
  logic [2:0][2:0][7:0]  swin_q;

  // Line store ports.
  logic             re;
  logic [AddrW-1:0] g_top, g_mid, m_top, m_mid, s_top, s_mid;
  logic             g_we, m_we, s_we;
  logic [7:0]       g_rdata, s_rdata, s_wdata;
  logic [9:0]       m_rdata, m_wdata;
  logic [7:0]       gtop_q, stop_q, smid_q;
  logic [9:0]       mtop_q, mmid_q;
  logic [7:0]       gray;

  // Gradient unit.
  logic       grad_start, grad_done;
  logic [7:0] grad_mag;
  logic [1:0] grad_sector;
  logic [9:0] magsec_q;

  // Output side.
  logic out_valid_q, edge_q, last_q;
  logic pix_ok3, last3, emit, out_free, hold, restart;
  logic [7:0] sup_val;
  logic       edge_val;

  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign size_we = cfg_we && (cfg_idx_e'(cfg_index_i) == CFG_WIDTH ||
                              cfg_idx_e'(cfg_index_i) == CFG_HEIGHT);

  // Stage enables, interior test and end of row for every stage.
  always_comb begin
    en[0] = 1'b1;
    for (int k = 1; k < 4; k++) begin
      en[k] = en[k-1] && (row_q[k-1] > RowW'(1) ||
                          (row_q[k-1] == RowW'(1) && col_q[k-1] != '0));
    end
    for (int k = 0; k < 4; k++) begin
      inner[k] = row_q[k] != '0 && 32'(row_q[k]) + 1 < 32'(h_q) &&
                 col_q[k] != '0 && 32'(col_q[k]) + 1 < 32'(w_q);
      last_col[k] = (32'(col_q[k]) + 1 == 32'(w_q));
    end
  end

  assign pix_ok3  = 32'(row_q[3]) < 32'(h_q);
  assign last3    = (32'(row_q[3]) + 1 == 32'(h_q)) && last_col[3];
  assign emit     = en[3] && pix_ok3;
  assign out_free = !out_valid_q || !out_stall_i;
  assign hold     = emit && !out_free;
  assign restart  = en[3] && (!pix_ok3 || last3);

  // Line store addresses: row parity picks the half, top is two rows back.
  assign g_top = {row_q[0][0], col_q[0]};
  assign g_mid = {~row_q[0][0], col_q[0]};
  assign m_top = {row_q[1][0], col_q[1]};
  assign m_mid = {~row_q[1][0], col_q[1]};
  assign s_top = {row_q[2][0], col_q[2]};
  assign s_mid = {~row_q[2][0], col_q[2]};

  assign gray = (32'(row_q[0]) < 32'(h_q)) ? gray_of(red_q, green_q, blue_q) : 8'd0;

  // Non-maximum suppression along the stored sector.
  always_comb begin
    logic [7:0] cur, n1, n2;
    cur = mwin_q[1][1][7:0];
    case (mwin_q[1][1][9:8])
      SEC_HORZ: begin
        n1 = mwin_q[1][0][7:0];
        n2 = mwin_q[1][2][7:0];
      end
      SEC_DIAG_UP: begin
        n1 = mwin_q[0][2][7:0];
        n2 = mwin_q[2][0][7:0];
      end
      SEC_VERT: begin
        n1 = mwin_q[0][1][7:0];
        n2 = mwin_q[2][1][7:0];
      end
      default: begin
        n1 = mwin_q[0][0][7:0];
        n2 = mwin_q[2][2][7:0];
      end
    endcase
    sup_val = (cur >= n1 && cur >= n2) ? cur : 8'd0;
  end

  // Hysteresis: strong, or weak with a strong neighbor.
  always_comb begin
    logic strong_nb;
    strong_nb = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && swin_q[r][c] >= high_q) strong_nb = 1'b1;
      end
    end
    if (swin_q[1][1] >= high_q) begin
      edge_val = 1'b1;
    end else if (swin_q[1][1] < low_q) begin
      edge_val = 1'b0;
    end else begin
      edge_val = strong_nb;
    end
    edge_val = edge_val && inner[3];
  end

  assign m_wdata = inner[1] ? magsec_q : 10'd0;
  assign s_wdata = inner[2] ? sup_val : 8'd0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && !in_stall_o) state_d = ST_RD_TOP;
      ST_RD_TOP: state_d = ST_RD_MID;
      ST_RD_MID: state_d = ST_GRAY;
      ST_GRAY:   state_d = ST_GRAD;
      ST_GRAD:   if (grad_done) state_d = ST_MAG;
      ST_MAG:    state_d = ST_SUPP;
      ST_SUPP:   state_d = ST_OUT;
      ST_OUT:    if (!hold) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
    cfg_ready_o = (state_q == ST_IDLE);
    re          = (state_q == ST_RD_TOP) || (state_q == ST_RD_MID);
    g_we        = (state_q == ST_GRAY);
    grad_start  = (state_q == ST_GRAY);
    m_we        = (state_q == ST_MAG) && en[1];
    s_we        = (state_q == ST_SUPP) && en[2];
  end

  ced_ram #(.Width(8), .Depth(Depth)) u_gray_rows (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_top),
    .wdata_i (gray),
    .re_i    (re),
    .raddr_i ((state_q == ST_RD_TOP) ? g_top : g_mid),
    .rdata_o (g_rdata)
  );

  ced_ram #(.Width(10), .Depth(Depth)) u_mag_rows (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_top),
    .wdata_i (m_wdata),
    .re_i    (re),
    .raddr_i ((state_q == ST_RD_TOP) ? m_top : m_mid),
    .rdata_o (m_rdata)
  );

  ced_ram #(.Width(8), .Depth(Depth)) u_sup_rows (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_top),
    .wdata_i (s_wdata),
    .re_i    (re),
    .raddr_i ((state_q == ST_RD_TOP) ? s_top : s_mid),
    .rdata_o (s_rdata)
  );

  ced_grad u_grad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (grad_start),
    .win_i    (gwin_q),
    .done_o   (grad_done),
    .mag_o    (grad_mag),
    .sector_o (grad_sector)
  );

  // Control state, configuration, positions and windows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= WEffW'(WRst);
      h_q         <= HEffW'(HRst);
      low_q       <= 8'd20;
      high_q      <= 8'd70;
      out_valid_q <= 1'b0;
      gwin_q      <= '0;
      mwin_q      <= '0;
      swin_q      <= '0;
      for (int k = 0; k < 4; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH: begin
            if (cfg_data_i[10:0] < 11'd3) w_q <= WEffW'(3);
            else if (32'(cfg_data_i[10:0]) > MAX_WIDTH) w_q <= WEffW'(MAX_WIDTH);
            else w_q <= WEffW'(cfg_data_i[10:0]);
          end
          CFG_HEIGHT: begin
            if (cfg_data_i < 12'd3) h_q <= HEffW'(3);
            else if (32'(cfg_data_i) > MAX_HEIGHT) h_q <= HEffW'(MAX_HEIGHT);
            else h_q <= HEffW'(cfg_data_i);
          end
          CFG_LOW:  low_q  <= cfg_data_i[7:0];
          default:  high_q <= cfg_data_i[7:0];
        endcase
      end

      // A new result is loaded only when the output register is free.
      if (state_q == ST_OUT && !hold && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_GRAY: begin
          for (int r = 0; r < 3; r++) begin
            gwin_q[r][0] <= gwin_q[r][1];
            gwin_q[r][1] <= gwin_q[r][2];
          end
          gwin_q[0][2] <= gtop_q;
          gwin_q[1][2] <= g_rdata;
          gwin_q[2][2] <= gray;
        end
        ST_MAG: begin
          if (en[1]) begin
            for (int r = 0; r < 3; r++) begin
              mwin_q[r][0] <= mwin_q[r][1];
              mwin_q[r][1] <= mwin_q[r][2];
            end
            mwin_q[0][2] <= mtop_q;
            mwin_q[1][2] <= mmid_q;
            mwin_q[2][2] <= m_wdata;
          end
        end
        ST_SUPP: begin
          if (en[2]) begin
            for (int r = 0; r < 3; r++) begin
              swin_q[r][0] <= swin_q[r][1];
              swin_q[r][1] <= swin_q[r][2];
            end
            swin_q[0][2] <= stop_q;
            swin_q[1][2] <= smid_q;
            swin_q[2][2] <= s_wdata;
          end
        end
        default: ;
      endcase

      // Positions: a size write or the end of a frame restarts all stages.
      if (size_we || (state_q == ST_OUT && !hold && restart)) begin
        for (int k = 0; k < 4; k++) begin
          col_q[k] <= '0;
          row_q[k] <= '0;
        end
      end else if (state_q == ST_OUT && !hold) begin
        for (int k = 0; k < 4; k++) begin
          if (en[k]) begin
            if (last_col[k]) begin
              col_q[k] <= '0;
              row_q[k] <= row_q[k] + RowW'(1);
            end else begin
              col_q[k] <= col_q[k] + ColW'(1);
            end
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (state_q == ST_RD_MID) begin
      gtop_q <= g_rdata;
      mtop_q <= m_rdata;
      stop_q <= s_rdata;
    end
    if (state_q == ST_GRAY) begin
      mmid_q <= m_rdata;
      smid_q <= s_rdata;
    end
    if (state_q == ST_GRAD && grad_done) begin
      magsec_q <= {grad_sector, grad_mag};
    end
    if (state_q == ST_OUT && !hold && emit) begin
      edge_q <= edge_val;
      last_q <= last3;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign edge_res_o      = edge_q;
  assign last_in_frame_o = last_q;

endmodule

/* src/ced_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny edge stream checker
// Port-level checks of the edge detector, bound to the top level.
// ----------------------------------------------------------------------------
module ced_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic edge_res_o,
  input logic last_in_frame_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  // A held result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The sequencer works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("request taken while busy");

  // Configuration and a request never complete on the same edge.
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> in_stall_o)
    else $error("configuration write overlaps a request");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(edge_res_o) && $stable(last_in_frame_o))
    else $error("result payload changed while stalled");

endmodule

bind canny_edge_stream_core ced_checker u_ced_checker (.*);
